### rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Concurrent next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/trmt_pkg.sv
package trmt_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam logic [31:0] HoldTimeReset = 32'd30000;
  localparam logic [31:0] AgeStepReset = 32'd30000;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_TAKE = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_DONE      = 3'd5
  } status_t;

  localparam logic CFG_HOLD_TIME = 1'b0;
  localparam logic CFG_AGE_STEP = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic        is_binary;
    logic [15:0] code;
    logic [31:0] msg_id;
    logic [31:0] payload_handle;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] handle_out;
    logic [4:0]  occupancy;
    logic        last;
  } out_word_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_EXEC = 2'd1,
    BK_SWEEP = 2'd2,
    BK_DONE = 2'd3
  } bk_state_t;

endpackage

### rtl/core/tagged_reply_match_table_with_aging_top.sv
// Put/take: a word passes the input queue, EXEC (waits while the output is held), output register; one at a time.
// Tick: sweeps one slot per cycle, stalling on an expiring slot while the output word is still held.
// A two-word input queue and a one-word output register decouple both sides.
// Reset (rst, synchronous): table empty, order counter one, registers 30000.
// Configuration is accepted every cycle (ready tied high).
module tagged_reply_match_table_with_aging_top #(
  parameter int unsigned CAPACITY = trmt_pkg::CapacityDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  trmt_pkg::in_word_t  in_word,
  output logic                empty,
  input  logic                pop,
  output trmt_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  logic               q_valid;
  logic               q_take;
  trmt_pkg::in_word_t q_word;
  logic [31:0]        hold_time;
  logic [31:0]        age_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time <= trmt_pkg::HoldTimeReset;
      age_step <= trmt_pkg::AgeStepReset;
    end else if (cfg_valid) begin
      if (cfg_index == trmt_pkg::CFG_HOLD_TIME) hold_time <= cfg_data;
      if (cfg_index == trmt_pkg::CFG_AGE_STEP) age_step <= cfg_data;
    end
  end

  trmt_front u_front (
    .clk, .rst, .push, .full, .in_word,
    .q_valid, .q_word, .q_take
  );

  trmt_back #(.CAPACITY(CAPACITY)) u_back (
    .clk, .rst, .q_valid, .q_word, .q_take,
    .hold_time, .age_step, .empty, .pop, .out_word
  );
endmodule

### rtl/core/trmt_front.sv
// Input queue: accepts words, drops unused operations, holds two words.
module trmt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  trmt_pkg::in_word_t in_word,
  output logic               q_valid,
  output trmt_pkg::in_word_t q_word,
  input  logic               q_take
);
  trmt_pkg::in_word_t slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  assign full = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_word = slot[rd_ptr];
  assign rd_en = q_take && q_valid;
  // Classify: unused operation code is dropped at the door.
  assign wr_en = push && !full &&
                 (in_word.operation != trmt_pkg::OP_NONE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

### rtl/core/trmt_back.sv
// Table engine: tag compare for take, lowest free slot for put, one slot per cycle for ticks unless output stalls.
module trmt_back #(
  parameter int unsigned CAPACITY = trmt_pkg::CapacityDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  trmt_pkg::in_word_t  q_word,
  output logic                q_take,
  input  logic [31:0]         hold_time,
  input  logic [31:0]         age_step,
  output logic                empty,
  input  logic                pop,
  output trmt_pkg::out_word_t out_word
);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned P = 1 << IW;

  logic [CAPACITY-1:0] valid;
  logic                bin_r [CAPACITY];
  logic [15:0]         code_r [CAPACITY];
  logic [31:0]         id_r [CAPACITY];
  logic [31:0]         ttl_r [CAPACITY];
  logic [31:0]         handle_r [CAPACITY];
  logic [63:0]         order_r [CAPACITY];
  logic [63:0]         next_order;
  logic [CW-1:0]       live;

  trmt_pkg::bk_state_t state, state_next;
  trmt_pkg::in_word_t  cur;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       free_idx;
  logic                free_any;
  logic [IW-1:0]       best_idx;
  logic                best_any;
  logic                node_any [2*P];
  logic [IW-1:0]       node_idx [2*P];
  logic [63:0]         node_ord [2*P];
  logic                sweep_last;
  logic                out_full;
  logic                out_load;
  trmt_pkg::out_word_t res;
  logic                res_valid;
  logic [CW-1:0]       live_after;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  // Matching entry with smallest order, lowest slot on a tie: compare tree,
  // left side wins unless the right side is strictly older.
  always_comb begin
    for (int i = 0; i < 2 * P; i++) begin
      node_any[i] = 1'b0;
      node_idx[i] = '0;
      node_ord[i] = '0;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      node_any[P + i] = valid[i] && id_r[i] == cur.msg_id && code_r[i] == cur.code &&
                        bin_r[i] == cur.is_binary;
      node_idx[P + i] = IW'(i);
      node_ord[P + i] = order_r[i];
    end
    for (int n = P - 1; n >= 1; n--) begin
      if (node_any[2*n+1] && (!node_any[2*n] || node_ord[2*n+1] < node_ord[2*n])) begin
        node_any[n] = 1'b1;
        node_idx[n] = node_idx[2*n+1];
        node_ord[n] = node_ord[2*n+1];
      end else begin
        node_any[n] = node_any[2*n];
        node_idx[n] = node_idx[2*n];
        node_ord[n] = node_ord[2*n];
      end
    end
    best_any = node_any[1];
    best_idx = node_idx[1];
  end

  assign sweep_last = ({1'b0, idx} == (IW + 1)'(CAPACITY - 1));
  assign empty = !out_full;
  assign out_load = res_valid;

  always_comb begin
    state_next = state;
    case (state)
      trmt_pkg::BK_IDLE: if (q_valid) state_next = trmt_pkg::BK_EXEC;
      trmt_pkg::BK_EXEC: begin
        if (!out_full) begin
          state_next = (cur.operation == trmt_pkg::OP_TICK) ?
                       trmt_pkg::BK_SWEEP : trmt_pkg::BK_IDLE;
        end
      end
      trmt_pkg::BK_SWEEP: begin
        if (sweep_last && (!valid[idx] || ttl_r[idx] > age_step || !out_full)) begin
          state_next = trmt_pkg::BK_DONE;
        end
      end
      trmt_pkg::BK_DONE: if (!out_full) state_next = trmt_pkg::BK_IDLE;
      default: state_next = trmt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_take = (state == trmt_pkg::BK_IDLE) && q_valid;
    res_valid = 1'b0;
    res = '0;
    live_after = live;
    case (state)
      trmt_pkg::BK_EXEC: begin
        if (!out_full && cur.operation == trmt_pkg::OP_PUT) begin
          res_valid = 1'b1;
          res.last = 1'b1;
          if (free_any) begin
            res.status = trmt_pkg::ST_STORED;
            live_after = live + 1'b1;
          end else begin
            res.status = trmt_pkg::ST_FULL;
          end
        end else if (!out_full && cur.operation == trmt_pkg::OP_TAKE) begin
          res_valid = 1'b1;
          res.last = 1'b1;
          if (best_any) begin
            res.status = trmt_pkg::ST_FOUND;
            res.handle_out = handle_r[best_idx];
            live_after = live - 1'b1;
          end else begin
            res.status = trmt_pkg::ST_NOT_FOUND;
          end
        end
      end
      trmt_pkg::BK_SWEEP: begin
        if (!out_full && valid[idx] && ttl_r[idx] <= age_step) begin
          res_valid = 1'b1;
          res.status = trmt_pkg::ST_EXPIRED;
          res.handle_out = handle_r[idx];
          live_after = live - 1'b1;
        end
      end
      trmt_pkg::BK_DONE: begin
        if (!out_full) begin
          res_valid = 1'b1;
          res.status = trmt_pkg::ST_DONE;
          res.last = 1'b1;
        end
      end
      default: ;
    endcase
    res.occupancy = 5'(live_after);
  end

  always_ff @(posedge clk) begin
    if (q_take) cur <= q_word;
    if (out_load) out_word <= res;
    if (state == trmt_pkg::BK_EXEC && !out_full && cur.operation == trmt_pkg::OP_PUT &&
        free_any) begin
      bin_r[free_idx] <= cur.is_binary;
      code_r[free_idx] <= cur.code;
      id_r[free_idx] <= cur.msg_id;
      ttl_r[free_idx] <= hold_time;
      handle_r[free_idx] <= cur.payload_handle;
      order_r[free_idx] <= next_order;
    end
    if (state == trmt_pkg::BK_SWEEP && valid[idx] && ttl_r[idx] > age_step) begin
      ttl_r[idx] <= ttl_r[idx] - age_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trmt_pkg::BK_IDLE;
      valid <= '0;
      next_order <= 64'd1;
      live <= '0;
      idx <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      live <= live_after;
      if (out_load) out_full <= 1'b1;
      else if (pop && out_full) out_full <= 1'b0;
      if (state == trmt_pkg::BK_EXEC && !out_full) begin
        idx <= '0;
        if (cur.operation == trmt_pkg::OP_PUT && free_any) begin
          valid[free_idx] <= 1'b1;
          next_order <= next_order + 64'd1;
        end
        if (cur.operation == trmt_pkg::OP_TAKE && best_any) valid[best_idx] <= 1'b0;
      end
      if (state == trmt_pkg::BK_SWEEP) begin
        // Stall on an expiring slot while the output word is still held.
        if (!valid[idx] || ttl_r[idx] > age_step) begin
          if (!sweep_last) idx <= idx + 1'b1;
        end else if (!out_full) begin
          valid[idx] <= 1'b0;
          if (!sweep_last) idx <= idx + 1'b1;
        end
      end
    end
  end
endmodule

### rtl/core/trmt_checker.sv
`include "assert_macros.svh"

module trmt_checker (
  input logic                clk,
  input logic                rst,
  input logic                empty,
  input logic                pop,
  input trmt_pkg::out_word_t out_word
);
  `CHK_IMPL(a_occ_range, clk, rst, !empty, out_word.occupancy <= 5'd16, "occupancy too big")
  `CHK_IMPL(a_status_range, clk, rst, !empty, out_word.status <= trmt_pkg::ST_DONE, "bad status")
  `CHK_IMPL(a_last_done, clk, rst, !empty && out_word.status == trmt_pkg::ST_EXPIRED,
    !out_word.last, "expired word marked last")
  `CHK_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(out_word), "word changed")
endmodule

bind tagged_reply_match_table_with_aging_top trmt_checker u_chk (
  .clk, .rst, .empty, .pop, .out_word
);
